// ----- rtl/core/apid_pkg.sv -----
// ----------------------------------------------------------------------------
// apid_pkg
// Shared types and constants for the attitude pid tick with leaky integral.
// ----------------------------------------------------------------------------
package apid_pkg;

    // field widths
    localparam int TARGET_W = 13;
    localparam int ANGLE_W  = 16;
    localparam int RATE_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int INTEG_W  = 16;
    localparam int DRIVE_W  = 18;
    localparam int CFG_IDX_W = 2;

    // internal widths
    localparam int ERR_W   = 17;
    localparam int SUM_W   = 26;
    localparam int SUM9_W  = 30;
    localparam int MAG1_W  = 18;
    localparam int MAG2_W  = 19;
    localparam int MUL_W   = 20;
    localparam int PROD_W  = 40;
    localparam int ACC_W   = 42;
    localparam int QLO_W   = 34;
    localparam int DIVX_W  = 30;
    localparam int DMAG_W  = 17;

    // limits and reciprocal constants
    localparam int INTEG_LIMIT = 25600;
    localparam int DRIVE_LIMIT = 76800;
    localparam int LEAK_OVER   = 256010;   // 10 * (INTEG_LIMIT + 1)
    localparam int DRIVE_OVER  = 384005;   // 5 * (DRIVE_LIMIT + 1)
    localparam int RECIP10     = 209716;   // ceil(2^21 / 10)
    localparam int RECIP5      = 419431;   // ceil(2^21 / 5)
    localparam int RECIP_SHIFT = 21;
    localparam int DRIVE_SHIFT = 12;       // 20480 = 5 * 4096

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd270;
    localparam logic [GAIN_W-1:0] GAIN_I_RESET = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_R_RESET = 16'd975;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_R = 2'd2;

    // sequencer steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ABS1,
        ST_DIV10,
        ST_INTEG,
        ST_MR,
        ST_MI,
        ST_ACC,
        ST_ABS2,
        ST_DIV5,
        ST_OUT
    } step_t;

    typedef struct packed {
        step_t step;
        logic  in_ready;
        logic  load_out;
    } seq_ctrl_t;

endpackage

// ----- rtl/core/apid_if.sv -----
// ----------------------------------------------------------------------------
// apid_if
// Valid/ready channels of the attitude pid block: sample, result and config.
// ----------------------------------------------------------------------------
interface apid_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [apid_pkg::TARGET_W-1:0] target_angle;
    logic signed [apid_pkg::ANGLE_W-1:0]  measured_angle;
    logic signed [apid_pkg::RATE_W-1:0]   measured_rate;

    modport source (output valid, output target_angle, output measured_angle,
                    output measured_rate, input ready);
    modport sink (input valid, input target_angle, input measured_angle,
                  input measured_rate, output ready);
endinterface

interface apid_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [apid_pkg::DRIVE_W-1:0] drive;
    logic                                saturated;

    modport source (output valid, output drive, output saturated, input ready);
    modport sink (input valid, input drive, input saturated, output ready);
endinterface

interface apid_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [apid_pkg::CFG_IDX_W-1:0]      reg_index;
    logic [apid_pkg::GAIN_W-1:0]         wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/core/apid_mul.sv -----
// ----------------------------------------------------------------------------
// apid_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module apid_mul (
    input  logic                                clk,
    input  logic signed [apid_pkg::MUL_W-1:0]   op_a,
    input  logic signed [apid_pkg::MUL_W-1:0]   op_b,
    output logic signed [apid_pkg::PROD_W-1:0]  prod
);
    import apid_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/apid_seq.sv -----
// ----------------------------------------------------------------------------
// apid_seq
// Step sequencer for one control tick.
// ----------------------------------------------------------------------------
module apid_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 out_free,
    output apid_pkg::seq_ctrl_t  ctrl
);
    import apid_pkg::*;

    step_t state_reg;
    step_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl.step     = state_reg;
        ctrl.in_ready = 1'b0;
        ctrl.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_ABS1;
            ST_ABS1:  state_next = ST_DIV10;
            ST_DIV10: state_next = ST_INTEG;
            ST_INTEG: state_next = ST_MR;
            ST_MR:    state_next = ST_MI;
            ST_MI:    state_next = ST_ACC;
            ST_ACC:   state_next = ST_ABS2;
            ST_ABS2:  state_next = ST_DIV5;
            ST_DIV5:  state_next = ST_OUT;
            ST_OUT:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/attitude_pid_leaky_integral.sv -----
// ----------------------------------------------------------------------------
// attitude_pid_leaky_integral
// One attitude-axis pid tick per item, with a leaky, sign-reset integral.
// ----------------------------------------------------------------------------
// Each item is taken in the idle step and then runs through ten sequencer
// steps, the last of which loads the result into the output register once
// that register is free. One shared 20x20 signed multiplier is stepped
// five times (the divide-by-10 of the leak, the three gain products and the
// divide-by-5 of the drive), with add, absolute value and scaling steps in
// between. One item is worked on at a time and sample.ready is low while
// it runs through those steps. The result sits in an output
// register, so the next item is accepted while a finished result still waits
// to be taken; a second result waits in the last step until the register is
// free. Gain writes on cfg are always taken and are meant to happen only
// while the block is idle.
// ----------------------------------------------------------------------------
module attitude_pid_leaky_integral (
    input  logic       clk,
    input  logic       rst_n,
    apid_in_if.sink    sample,
    apid_out_if.source result,
    apid_cfg_if.sink   cfg
);
    import apid_pkg::*;

    // configuration registers
    logic [GAIN_W-1:0] gain_p_reg;
    logic [GAIN_W-1:0] gain_i_reg;
    logic [GAIN_W-1:0] gain_r_reg;

    // integral state
    logic [INTEG_W-1:0] integ_reg;
    logic [INTEG_W-1:0] integ_next;

    // per-item working registers
    logic [ERR_W-1:0]   err_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM9_W-1:0]  sum9_reg;
    logic [MAG1_W-1:0]  mag1_reg;
    logic               neg1_reg;
    logic               over1_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [MAG2_W-1:0]  mag2_reg;
    logic               neg2_reg;
    logic               over2_reg;

    // output register
    logic               out_valid_reg;
    logic [DRIVE_W-1:0] drive_reg;
    logic               sat_reg;

    seq_ctrl_t          ctrl;
    logic               take_item;
    logic               out_free;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]         prod_ext;

    logic [ERR_W-1:0]   err_in;
    logic [SUM_W-1:0]   sum_in;
    logic [SUM9_W-1:0]  sum9_in;
    logic [SUM9_W-1:0]  mag1_full;
    logic [INTEG_W-1:0] leak_mag;
    logic [INTEG_W-1:0] leak_val;
    logic               err_neg;
    logic               err_pos;
    logic [ACC_W-1:0]   acc_mag;
    logic [DIVX_W-1:0]  acc_div;
    logic [DMAG_W-1:0]  drive_mag;
    logic [DRIVE_W-1:0] drive_val;

    apid_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    apid_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign sample.ready = ctrl.in_ready;
    assign take_item    = sample.valid && ctrl.in_ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign cfg.ready    = 1'b1;

    // error and pre-leak sum, formed as the item is taken
    assign err_in = {{(ERR_W - TARGET_W){sample.target_angle[TARGET_W-1]}},
                     sample.target_angle}
                  - {{(ERR_W - ANGLE_W){sample.measured_angle[ANGLE_W-1]}},
                     sample.measured_angle};
    assign sum_in = {{(SUM_W - INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg}
                  + {err_in[ERR_W-1], err_in, 8'b0};

    // sum * 9 as shift and add
    assign sum9_in = {sum_reg[SUM_W-1], sum_reg, 3'b0}
                   + {{(SUM9_W - SUM_W){sum_reg[SUM_W-1]}}, sum_reg};

    assign mag1_full = sum9_reg[SUM9_W-1] ? (~sum9_reg + 1'b1) : sum9_reg;

    // leak: |sum*9| / 10 by reciprocal, then clamp, sign and sign reset
    assign leak_mag = over1_reg ? INTEG_W'(INTEG_LIMIT)
                                : prod[RECIP_SHIFT +: INTEG_W];
    assign err_neg  = err_reg[ERR_W-1];
    assign err_pos  = !err_reg[ERR_W-1] && (err_reg != '0);

    always_comb
    begin
        leak_val = neg1_reg ? (~leak_mag + 1'b1) : leak_mag;
        // integral opposing the error is dropped
        if ((leak_mag != '0) && ((!neg1_reg && err_neg) || (neg1_reg && err_pos)))
        begin
            integ_next = '0;
        end
        else
        begin
            integ_next = leak_val;
        end
    end

    assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

    // drive magnitude, scaled by 1/4096 ahead of the divide by 5
    assign acc_mag = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign acc_div = acc_mag[DRIVE_SHIFT +: DIVX_W];

    assign drive_mag = over2_reg ? DMAG_W'(DRIVE_LIMIT) : prod[RECIP_SHIFT +: DMAG_W];
    assign drive_val = neg2_reg ? (~{1'b0, drive_mag} + 1'b1) : {1'b0, drive_mag};

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.step)
            ST_DIV10:
            begin
                mul_a = {{(MUL_W - MAG1_W){1'b0}}, mag1_reg};
                mul_b = MUL_W'(RECIP10);
            end
            ST_INTEG:
            begin
                mul_a = {{(MUL_W - GAIN_W){gain_p_reg[GAIN_W-1]}}, gain_p_reg};
                mul_b = {{(MUL_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            ST_MR:
            begin
                mul_a = {{(MUL_W - GAIN_W){gain_r_reg[GAIN_W-1]}}, gain_r_reg};
                mul_b = {{(MUL_W - RATE_W){rate_reg[RATE_W-1]}}, rate_reg};
            end
            ST_MI:
            begin
                mul_a = {{(MUL_W - GAIN_W){gain_i_reg[GAIN_W-1]}}, gain_i_reg};
                mul_b = {{(MUL_W - INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
            end
            ST_DIV5, ST_OUT:
            begin
                // kept on while the result waits so the quotient stays valid
                mul_a = {{(MUL_W - MAG2_W){1'b0}}, mag2_reg};
                mul_b = MUL_W'(RECIP5);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_P_RESET;
            gain_i_reg <= GAIN_I_RESET;
            gain_r_reg <= GAIN_R_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.reg_index == REG_GAIN_P)
            begin
                gain_p_reg <= cfg.wdata;
            end
            if (cfg.reg_index == REG_GAIN_I)
            begin
                gain_i_reg <= cfg.wdata;
            end
            if (cfg.reg_index == REG_GAIN_R)
            begin
                gain_r_reg <= cfg.wdata;
            end
        end
    end

    // integral state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.step == ST_INTEG)
            begin
                integ_reg <= integ_next;
            end
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, stepped by the sequencer
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            err_reg  <= err_in;
            rate_reg <= sample.measured_rate;
            sum_reg  <= sum_in;
        end
        unique case (ctrl.step)
            ST_SCALE:
            begin
                sum9_reg <= sum9_in;
            end
            ST_ABS1:
            begin
                neg1_reg  <= sum9_reg[SUM9_W-1];
                over1_reg <= (mag1_full >= SUM9_W'(LEAK_OVER));
                mag1_reg  <= mag1_full[MAG1_W-1:0];
            end
            ST_MR:
            begin
                acc_reg <= prod_ext;
            end
            ST_MI:
            begin
                acc_reg <= acc_reg - prod_ext;
            end
            ST_ACC:
            begin
                acc_reg <= {acc_reg[QLO_W-1:0], 8'b0} + prod_ext;
            end
            ST_ABS2:
            begin
                neg2_reg  <= acc_reg[ACC_W-1];
                over2_reg <= (acc_div >= DIVX_W'(DRIVE_OVER));
                mag2_reg  <= acc_div[MAG2_W-1:0];
            end
            default:
            begin
            end
        endcase
        if (ctrl.load_out)
        begin
            drive_reg <= drive_val;
            sat_reg   <= over2_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.drive     = drive_reg;
    assign result.saturated = sat_reg;

endmodule

// ----- rtl/core/apid_checker.sv -----
// ----------------------------------------------------------------------------
// apid_checker
// Port-level checks for the attitude pid block, bound to the top level.
// ----------------------------------------------------------------------------
module apid_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               r_valid,
    input logic                               r_ready,
    input logic signed [apid_pkg::DRIVE_W-1:0] r_drive,
    input logic                               r_saturated
);
    import apid_pkg::*;

    // a pending result stays until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid)
        else $error("result dropped before it was taken");

    // one item at a time: busy right after taking an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready |=> !s_ready)
        else $error("sample taken while busy");

    // a clipped drive sits exactly on a limit
    a_sat_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_saturated |->
            (r_drive == DRIVE_W'(DRIVE_LIMIT)) || (r_drive == -DRIVE_W'(DRIVE_LIMIT)))
        else $error("saturated drive off the limit");

    // drive never leaves the limits
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |->
            (r_drive <= $signed(DRIVE_W'(DRIVE_LIMIT))) &&
            (r_drive >= -$signed(DRIVE_W'(DRIVE_LIMIT))))
        else $error("drive out of range");

endmodule

bind attitude_pid_leaky_integral apid_checker u_apid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_valid     (sample.valid),
    .s_ready     (sample.ready),
    .r_valid     (result.valid),
    .r_ready     (result.ready),
    .r_drive     (result.drive),
    .r_saturated (result.saturated)
);

// ----- tb/sv/attitude_pid_leaky_integral_checker.sv -----
// ----------------------------------------------------------------------------
// attitude_pid_leaky_integral_checker
// Watches the sample, result and cfg channels, predicts each tick's drive
// and saturation flag from its own copy of the gains and the leaky integral,
// and compares every result item in order.
// ----------------------------------------------------------------------------
module attitude_pid_leaky_integral_checker
    import apid_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       smp_valid,
    input  logic                       smp_ready,
    input  logic signed [TARGET_W-1:0] smp_target,
    input  logic signed [ANGLE_W-1:0]  smp_angle,
    input  logic signed [RATE_W-1:0]   smp_rate,
    input  logic                       res_valid,
    input  logic                       res_ready,
    input  logic signed [DRIVE_W-1:0]  res_drive,
    input  logic                       res_saturated,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [GAIN_W-1:0]          cfg_wdata,
    output int                         mismatches,
    output int                         pending
);

    localparam longint Q8_ONE        = 256;
    localparam longint DRIVE_DIVISOR = 20480;   // divide by 5, q.20 down to q.8

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } drive_item_t;

    drive_item_t expected_drive_q[$];

    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_r;
    logic signed [INTEG_W-1:0] integ_state;

    // one control tick: leaky integral update, then the clipped drive
    function automatic void predict_drive(
        input  logic signed [TARGET_W-1:0] tgt,
        input  logic signed [ANGLE_W-1:0]  ang,
        input  logic signed [RATE_W-1:0]   rate,
        output logic signed [DRIVE_W-1:0]  drv,
        output logic                       clip
    );
        longint err;
        longint sum;
        longint leak;
        longint acc;
        longint q;
        err  = longint'(tgt) - longint'(ang);
        sum  = longint'(integ_state) + err * Q8_ONE;
        leak = (sum * 9) / 10;
        if (leak > INTEG_LIMIT)
            leak = INTEG_LIMIT;
        else if (leak < -INTEG_LIMIT)
            leak = -INTEG_LIMIT;
        // integral cleared when it points against the error
        if ((leak > 0 && err < 0) || (leak < 0 && err > 0))
            leak = 0;
        integ_state = leak[INTEG_W-1:0];
        acc = longint'(gain_p) * err * Q8_ONE
            + longint'(gain_i) * leak
            - longint'(gain_r) * longint'(rate) * Q8_ONE;
        q    = acc / DRIVE_DIVISOR;
        clip = 1'b0;
        if (q > DRIVE_LIMIT)
        begin
            q    = DRIVE_LIMIT;
            clip = 1'b1;
        end
        else if (q < -DRIVE_LIMIT)
        begin
            q    = -DRIVE_LIMIT;
            clip = 1'b1;
        end
        drv = q[DRIVE_W-1:0];
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_item_t want;
        logic signed [DRIVE_W-1:0] drv;
        logic clip;
        if (!rst_n)
        begin
            expected_drive_q.delete();
            gain_p      = GAIN_P_RESET;
            gain_i      = GAIN_I_RESET;
            gain_r      = GAIN_R_RESET;
            integ_state = '0;
            mismatches  = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_P: gain_p = cfg_wdata;
                    REG_GAIN_I: gain_i = cfg_wdata;
                    REG_GAIN_R: gain_r = cfg_wdata;
                    default: ;
                endcase
            end
            if (res_valid && res_ready)
            begin
                if (expected_drive_q.size() == 0)
                    flag_mismatch($sformatf("unexpected result: drive=%0d saturated=%0b",
                                            res_drive, res_saturated));
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (res_drive !== want.drive || res_saturated !== want.saturated)
                        flag_mismatch($sformatf(
                            "drive mismatch: expected drive=%0d saturated=%0b, got drive=%0d saturated=%0b",
                            want.drive, want.saturated, res_drive, res_saturated));
                end
            end
            if (smp_valid && smp_ready)
            begin
                predict_drive(smp_target, smp_angle, smp_rate, drv, clip);
                want.drive     = drv;
                want.saturated = clip;
                expected_drive_q.push_back(want);
            end
            pending = expected_drive_q.size();
        end
    end

endmodule

// ----- tb/sv/attitude_pid_leaky_integral_test.sv -----
// ----------------------------------------------------------------------------
// attitude_pid_leaky_integral_test
// Drives control ticks and gain writes into the attitude pid block under
// random idling on both channels and a long output hold-off; a separate
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module attitude_pid_leaky_integral_test;
    import apid_pkg::*;

    // index past the end of the register list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = 16;      // longer than one tick
    localparam int HOLD_CYCLES  = 400;     // long output stall for back-pressure
    localparam int CHUNK_TICKS  = 46;      // ticks per gain setting
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;

    apid_in_if  sample_ch ();
    apid_out_if result_ch ();
    apid_cfg_if cfg_ch ();

    attitude_pid_leaky_integral DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    int mismatches;
    int pending;

    attitude_pid_leaky_integral_checker drive_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .smp_valid     (sample_ch.valid),
        .smp_ready     (sample_ch.ready),
        .smp_target    (sample_ch.target_angle),
        .smp_angle     (sample_ch.measured_angle),
        .smp_rate      (sample_ch.measured_rate),
        .res_valid     (result_ch.valid),
        .res_ready     (result_ch.ready),
        .res_drive     (result_ch.drive),
        .res_saturated (result_ch.saturated),
        .cfg_valid     (cfg_ch.valid),
        .cfg_ready     (cfg_ch.ready),
        .cfg_index     (cfg_ch.reg_index),
        .cfg_wdata     (cfg_ch.wdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // idle percentages per side, changed per phase
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_off;
    int   cycle_count;
    event hold_start;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // watchdog on total run length, counting from zero
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("attitude_pid_leaky_integral_test: FAIL");
            $finish;
        end
    end

    // result side: random ready, forced low while a hold-off runs
    always @(negedge clk)
    begin
        result_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // long hold-off, counted in its own process on the rising edge so the
    // ready driver sees a settled value at the falling edge
    initial
    begin
        hold_off = 1'b0;
        forever
        begin
            @(hold_start);
            @(posedge clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // one tick on the sample channel; entered and left at a falling edge,
    // valid stays high so back-to-back items need no lowering
    task automatic send_tick(input logic signed [TARGET_W-1:0] tgt,
                             input logic signed [ANGLE_W-1:0]  ang,
                             input logic signed [RATE_W-1:0]   rate);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid          = 1'b1;
        sample_ch.target_angle   = tgt;
        sample_ch.measured_angle = ang;
        sample_ch.measured_rate  = rate;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wdata     = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kr);
        write_gain(REG_GAIN_P, kp);
        write_gain(REG_GAIN_I, ki);
        write_gain(REG_GAIN_R, kr);
    endtask

    // lower valid, wait until every expected result is taken, then let the
    // block finish any tail work before touching the gains
    task automatic wait_drained();
        sample_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 8192) - 4096);   // around +-1.0
        endcase
    endfunction

    // mostly near-equilibrium ticks so the integral leaks and flips sign
    // instead of sitting at its clamp; the rest full-range patterns
    task automatic send_random_tick();
        int kind;
        int tv;
        int av;
        int rv;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            tv = $urandom_range(0, 600) - 300;
            av = tv + $urandom_range(0, 400) - 200;
            rv = $urandom_range(0, 4000) - 2000;
        end
        else if (kind < 8)
        begin
            tv = $urandom;
            av = $urandom;
            rv = $urandom;
        end
        else
        begin
            tv = $urandom_range(0, 8191) - 4096;
            av = $urandom_range(0, 2000) - 1000;
            rv = $urandom_range(0, 65535) - 32768;
        end
        send_tick(tv[TARGET_W-1:0], av[ANGLE_W-1:0], rv[RATE_W-1:0]);
    endtask

    initial
    begin
        int phase;
        int chunk;
        // block inputs known from time zero, result ready from the first
        // falling edge
        rst_n                    = 1'b0;
        sample_ch.valid          = 1'b0;
        sample_ch.target_angle   = '0;
        sample_ch.measured_angle = '0;
        sample_ch.measured_rate  = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.reg_index         = '0;
        cfg_ch.wdata             = '0;
        send_idle_pct            = 36;
        recv_idle_pct            = 56;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset gains, field extremes
        send_tick(0, 0, 0);
        send_tick(4095, -32768, 0);       // largest positive error
        send_tick(-4096, 32767, 0);       // largest negative error
        send_tick(0, 0, 32767);
        send_tick(0, 0, -32768);

        // unity integral gain: build the integral into its clamp, then an
        // error of opposite sign clears it
        wait_drained();
        write_gain(REG_GAIN_I, 16'd4096);
        send_tick(60, 0, 0);
        send_tick(60, 0, 0);
        send_tick(60, 0, 0);
        send_tick(-1, 0, 0);
        send_tick(0, 0, 0);

        // pure proportional 0.5: error 3000 lands exactly on the drive limit
        // (not flagged), 3001 is clipped
        wait_drained();
        set_gains(16'd2048, 16'd0, 16'd0);
        send_tick(3000, 0, 0);
        send_tick(-3000, 0, 0);
        send_tick(3001, 0, 0);
        send_tick(-3001, 0, 0);

        // gain extremes, plus a write past the register list that must be dropped
        wait_drained();
        set_gains(16'h8000, 16'h7fff, 16'h8000);
        write_gain(REG_UNUSED, 16'hffff);
        send_tick(4095, -32768, 32767);
        send_tick(-4096, 32767, -32768);
        send_tick(0, 0, 0);

        wait_drained();
        set_gains(16'h7fff, 16'h8000, 16'h7fff);
        send_tick(4095, -32768, -32768);
        send_tick(-4096, 32767, 32767);

        // random part: three idling phases, four gain settings each
        for (phase = 0; phase < 3; phase++)
        begin
            for (chunk = 0; chunk < 4; chunk++)
            begin
                wait_drained();
                case (phase)
                    0:
                    begin
                        send_idle_pct = 36;
                        recv_idle_pct = 56;
                    end
                    1:
                    begin
                        send_idle_pct = 56;
                        recv_idle_pct = 36;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                if (chunk == 0)
                    set_gains(16'h7fff, 16'h7fff, 16'h7fff);
                else if (chunk == 1)
                    set_gains(16'h8000, 16'h8000, 16'h8000);
                else
                    set_gains(pick_gain(), pick_gain(), pick_gain());
                // back-pressure: result side stalls while ticks keep coming
                if (phase == 2 && chunk == 1)
                    -> hold_start;
                repeat (CHUNK_TICKS) send_random_tick();
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("attitude_pid_leaky_integral_test: PASS");
        else
            $display("attitude_pid_leaky_integral_test: FAIL");
        $finish;
    end

endmodule
